// ===== hdl/accel_tilt_angles_assert.svh =====
// Assertion macros shared by the tilt angle block.
`ifndef ACCEL_TILT_ANGLES_ASSERT_SVH
`define ACCEL_TILT_ANGLES_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define AT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Property that must hold in the same cycle whenever the antecedent holds.
`define AT_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/at_pkg.sv =====
// Shared constants, types and the arctangent step table of the tilt angle block.
package at_pkg;

    localparam int QDEPTH     = 4;
    localparam int QCNT_W     = 3;
    localparam int QPTR_W     = 2;
    localparam int ROOT_W     = 32;
    localparam int REM_W      = 35;
    localparam int RAD_W      = 64;
    localparam int CX_W       = 36;
    localparam int ACC_W      = 32;
    localparam int ACC_FRAC   = 16;
    localparam int FULL_ANGLE = 9000;
    localparam int MAG_W      = 14;
    localparam int ANGLE_W    = 15;
    localparam int TABLE_LEN  = 24;

    typedef struct packed {
        logic              avail;
        logic [QCNT_W-1:0] count;
    } q_status_t;

    // atan(2^-i) in centidegrees with 16 fraction bits.
    function automatic logic signed [ACC_W-1:0] atan_step(input logic [4:0] idx);
        logic signed [ACC_W-1:0] v;
        case (idx)
            5'd0:    v = 32'sd294912000;
            5'd1:    v = 32'sd174096719;
            5'd2:    v = 32'sd91987925;
            5'd3:    v = 32'sd46694507;
            5'd4:    v = 32'sd23437865;
            5'd5:    v = 32'sd11730358;
            5'd6:    v = 32'sd5866610;
            5'd7:    v = 32'sd2933484;
            5'd8:    v = 32'sd1466764;
            5'd9:    v = 32'sd733385;
            5'd10:   v = 32'sd366693;
            5'd11:   v = 32'sd183346;
            5'd12:   v = 32'sd91673;
            5'd13:   v = 32'sd45837;
            5'd14:   v = 32'sd22918;
            5'd15:   v = 32'sd11459;
            5'd16:   v = 32'sd5730;
            5'd17:   v = 32'sd2865;
            5'd18:   v = 32'sd1432;
            5'd19:   v = 32'sd716;
            5'd20:   v = 32'sd358;
            5'd21:   v = 32'sd179;
            5'd22:   v = 32'sd90;
            5'd23:   v = 32'sd45;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/at_front.sv =====
// Front end: accepts samples, forms magnitudes and sums of squares, feeds the queue.
module at_front #(
    parameter int SB      = 16,
    parameter int ENTRY_W = 6 * SB + 2
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    sample_valid,
    output logic                    sample_stall,
    input  logic [SB-1:0]           accel_x,
    input  logic [SB-1:0]           accel_y,
    input  logic [SB-1:0]           accel_z,
    input  at_pkg::q_status_t       q_stat,
    output logic                    push,
    output logic [ENTRY_W-1:0]      push_data
);

    logic          f_vld_reg;
    logic [SB-1:0] x_reg;
    logic [SB-1:0] y_reg;
    logic [SB-1:0] z_reg;
    logic [SB-1:0] ux;
    logic [SB-1:0] uy;
    logic [SB-1:0] uz;
    logic [2*SB-1:0] xx;
    logic [2*SB-1:0] yy;
    logic [2*SB-1:0] zz;
    logic [at_pkg::QCNT_W:0] used;

    // The item held here is counted against the queue so it always has a slot.
    assign used = {1'b0, q_stat.count} + (at_pkg::QCNT_W + 1)'(f_vld_reg);
    assign sample_stall = (used >= (at_pkg::QCNT_W + 1)'(at_pkg::QDEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
        end
        else
        begin
            f_vld_reg <= sample_valid && !sample_stall;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && !sample_stall)
        begin
            x_reg <= accel_x;
            y_reg <= accel_y;
            z_reg <= accel_z;
        end
    end

    assign ux = x_reg[SB-1] ? (~x_reg + 1'b1) : x_reg;
    assign uy = y_reg[SB-1] ? (~y_reg + 1'b1) : y_reg;
    assign uz = z_reg[SB-1] ? (~z_reg + 1'b1) : z_reg;

    assign xx = {{SB{1'b0}}, ux} * {{SB{1'b0}}, ux};
    assign yy = {{SB{1'b0}}, uy} * {{SB{1'b0}}, uy};
    assign zz = {{SB{1'b0}}, uz} * {{SB{1'b0}}, uz};

    assign push      = f_vld_reg;
    assign push_data = {yy + zz, xx + zz, ux, uy, x_reg[SB-1], y_reg[SB-1]};

endmodule

// ===== hdl/at_queue.sv =====
// Short queue between the front end and the angle pipeline.
module at_queue #(
    parameter int W = 98
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [W-1:0]      push_data,
    input  logic              pop,
    output logic [W-1:0]      head_data,
    output at_pkg::q_status_t q_stat
);

    logic [W-1:0]               mem [0:at_pkg::QDEPTH-1];
    logic [at_pkg::QPTR_W-1:0]  wptr_reg;
    logic [at_pkg::QPTR_W-1:0]  rptr_reg;
    logic [at_pkg::QCNT_W-1:0]  cnt_reg;
    logic [at_pkg::QCNT_W-1:0]  cnt_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= push_data;
        end
    end

    always_comb
    begin
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    assign head_data    = mem[rptr_reg];
    assign q_stat.avail = (cnt_reg != '0);
    assign q_stat.count = cnt_reg;

endmodule

// ===== hdl/at_back.sv =====
// Back end: pipelined square root and CORDIC vectoring for pitch and roll.
module at_back #(
    parameter int SB      = 16,
    parameter int ITERS   = 16,
    parameter int ENTRY_W = 6 * SB + 2
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  at_pkg::q_status_t                 q_stat,
    input  logic [ENTRY_W-1:0]                head_data,
    output logic                              pop,
    output logic                              angle_valid,
    input  logic                              angle_stall,
    output logic signed [at_pkg::ANGLE_W-1:0] pitch_centideg,
    output logic signed [at_pkg::ANGLE_W-1:0] roll_centideg,
    output logic                              pitch_undefined,
    output logic                              roll_undefined
);

    localparam int F       = 31 - SB;
    localparam int SHIFT2  = 2 * F;
    localparam int NI      = (ITERS > at_pkg::TABLE_LEN) ? at_pkg::TABLE_LEN : ITERS;
    localparam int RW      = at_pkg::ROOT_W;
    localparam int NS      = RW + NI;
    localparam int RAD_W_L = at_pkg::RAD_W;

    logic                 en;
    logic [NS-1:0]        vld_reg;
    logic                 angle_valid_reg;
    logic [2*SB-1:0]      lane_s   [0:1];
    logic [SB-1:0]        lane_mag [0:1];
    logic                 lane_neg [0:1];
    logic [at_pkg::ANGLE_W-1:0] lane_angle [0:1];
    logic                 lane_undef [0:1];

    // The whole pipeline advances unless a finished result is held back.
    assign en  = !(angle_valid_reg && angle_stall);
    assign pop = en && q_stat.avail;

    assign lane_s[0]   = head_data[6*SB+1 -: 2*SB];
    assign lane_s[1]   = head_data[4*SB+1 -: 2*SB];
    assign lane_mag[0] = head_data[2*SB+1 -: SB];
    assign lane_mag[1] = head_data[SB+1 -: SB];
    assign lane_neg[0] = head_data[1];
    assign lane_neg[1] = head_data[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg         <= '0;
            angle_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg         <= {vld_reg[NS-2:0], q_stat.avail};
            angle_valid_reg <= vld_reg[NS-1];
        end
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic [2*SB-1:0]                s_reg    [0:RW-1];
        logic [SB-1:0]                  mag_reg  [0:RW-1];
        logic                           neg_reg  [0:RW-1];
        logic [at_pkg::REM_W-1:0]       rem_reg  [0:RW-1];
        logic [RW-1:0]                  root_reg [0:RW-1];
        logic [at_pkg::REM_W-1:0]       rem_next [0:RW-1];
        logic [RW-1:0]                  root_next [0:RW-1];
        logic [2*SB-1:0]                s_next   [0:RW-1];
        logic [SB-1:0]                  mag_next [0:RW-1];
        logic                           neg_next [0:RW-1];

        logic signed [at_pkg::CX_W-1:0]  cx_reg   [0:NI-1];
        logic signed [at_pkg::CX_W-1:0]  cy_reg   [0:NI-1];
        logic signed [at_pkg::ACC_W-1:0] acc_reg  [0:NI-1];
        logic                            cneg_reg [0:NI-1];
        logic                            nz_reg   [0:NI-1];
        logic                            dz_reg   [0:NI-1];
        logic signed [at_pkg::CX_W-1:0]  cx_next  [0:NI-1];
        logic signed [at_pkg::CX_W-1:0]  cy_next  [0:NI-1];
        logic signed [at_pkg::ACC_W-1:0] acc_next [0:NI-1];
        logic                            cneg_next [0:NI-1];
        logic                            nz_next  [0:NI-1];
        logic                            dz_next  [0:NI-1];

        logic [at_pkg::ANGLE_W-1:0] angle_reg;
        logic [at_pkg::ANGLE_W-1:0] angle_next;
        logic                       undef_reg;
        logic                       undef_next;

        // Square root, one result bit per stage from two radicand bits.
        always_comb
        begin
            logic [2*SB-1:0]          s_in;
            logic [at_pkg::REM_W-1:0] r_in;
            logic [RW-1:0]            q_in;
            logic [RAD_W_L-1:0]       rad;
            logic [at_pkg::REM_W-1:0] r_sh;
            logic [at_pkg::REM_W-1:0] t;
            for (int k = 0; k < RW; k++)
            begin
                if (k == 0)
                begin
                    s_in        = lane_s[l];
                    r_in        = '0;
                    q_in        = '0;
                    mag_next[k] = lane_mag[l];
                    neg_next[k] = lane_neg[l];
                end
                else
                begin
                    s_in        = s_reg[k-1];
                    r_in        = rem_reg[k-1];
                    q_in        = root_reg[k-1];
                    mag_next[k] = mag_reg[k-1];
                    neg_next[k] = neg_reg[k-1];
                end
                rad  = RAD_W_L'(s_in) << SHIFT2;
                r_sh = {r_in[at_pkg::REM_W-3:0], rad[RAD_W_L-1-2*k -: 2]};
                t    = at_pkg::REM_W'({q_in, 2'b01});
                s_next[k] = s_in;
                if (r_sh >= t)
                begin
                    rem_next[k]  = r_sh - t;
                    root_next[k] = {q_in[RW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k]  = r_sh;
                    root_next[k] = {q_in[RW-2:0], 1'b0};
                end
            end
        end

        // CORDIC vectoring, one rotation per stage.
        always_comb
        begin
            logic signed [at_pkg::CX_W-1:0]  cx_in;
            logic signed [at_pkg::CX_W-1:0]  cy_in;
            logic signed [at_pkg::ACC_W-1:0] acc_in;
            logic signed [at_pkg::CX_W-1:0]  dx;
            logic signed [at_pkg::CX_W-1:0]  dy;
            for (int i = 0; i < NI; i++)
            begin
                if (i == 0)
                begin
                    cx_in        = at_pkg::CX_W'(root_reg[RW-1]);
                    cy_in        = at_pkg::CX_W'(mag_reg[RW-1]) << F;
                    acc_in       = '0;
                    cneg_next[i] = neg_reg[RW-1];
                    nz_next[i]   = (mag_reg[RW-1] == '0);
                    dz_next[i]   = (root_reg[RW-1] == '0);
                end
                else
                begin
                    cx_in        = cx_reg[i-1];
                    cy_in        = cy_reg[i-1];
                    acc_in       = acc_reg[i-1];
                    cneg_next[i] = cneg_reg[i-1];
                    nz_next[i]   = nz_reg[i-1];
                    dz_next[i]   = dz_reg[i-1];
                end
                dx = cy_in >>> i;
                dy = cx_in >>> i;
                if (!cy_in[at_pkg::CX_W-1])
                begin
                    cx_next[i]  = cx_in + dx;
                    cy_next[i]  = cy_in - dy;
                    acc_next[i] = acc_in + at_pkg::atan_step(5'(i));
                end
                else
                begin
                    cx_next[i]  = cx_in - dx;
                    cy_next[i]  = cy_in + dy;
                    acc_next[i] = acc_in - at_pkg::atan_step(5'(i));
                end
            end
        end

        // Clamp, round half up, apply the sign and the zero cases.
        always_comb
        begin
            logic signed [at_pkg::ACC_W-1:0] lim;
            logic signed [at_pkg::ACC_W-1:0] cl;
            logic [at_pkg::ACC_W-1:0]        rnd;
            logic [at_pkg::ANGLE_W-1:0]      mag;
            lim = at_pkg::ACC_W'(at_pkg::FULL_ANGLE) <<< at_pkg::ACC_FRAC;
            if (acc_reg[NI-1] < 0)
            begin
                cl = '0;
            end
            else if (acc_reg[NI-1] > lim)
            begin
                cl = lim;
            end
            else
            begin
                cl = acc_reg[NI-1];
            end
            rnd = at_pkg::ACC_W'(cl) + (at_pkg::ACC_W'(1) << (at_pkg::ACC_FRAC - 1));
            mag = {1'b0, rnd[at_pkg::ACC_FRAC +: at_pkg::MAG_W]};
            if (dz_reg[NI-1])
            begin
                mag = at_pkg::ANGLE_W'(at_pkg::FULL_ANGLE);
            end
            if (nz_reg[NI-1])
            begin
                angle_next = '0;
            end
            else if (cneg_reg[NI-1])
            begin
                angle_next = ~mag + 1'b1;
            end
            else
            begin
                angle_next = mag;
            end
            undef_next = nz_reg[NI-1] && dz_reg[NI-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_reg     <= s_next;
                mag_reg   <= mag_next;
                neg_reg   <= neg_next;
                rem_reg   <= rem_next;
                root_reg  <= root_next;
                cx_reg    <= cx_next;
                cy_reg    <= cy_next;
                acc_reg   <= acc_next;
                cneg_reg  <= cneg_next;
                nz_reg    <= nz_next;
                dz_reg    <= dz_next;
                angle_reg <= angle_next;
                undef_reg <= undef_next;
            end
        end

        assign lane_angle[l] = angle_reg;
        assign lane_undef[l] = undef_reg;
    end

    assign angle_valid     = angle_valid_reg;
    assign pitch_centideg  = lane_angle[0];
    assign roll_centideg   = lane_angle[1];
    assign pitch_undefined = lane_undef[0];
    assign roll_undefined  = lane_undef[1];

endmodule

// ===== hdl/accel_tilt_angles.sv =====
// Top level of the accelerometer pitch and roll tilt angle block.
// Input channel: sample_valid / sample_stall carry one item of signed
// accel_x, accel_y and accel_z. Output channel: angle_valid / angle_stall
// carry pitch_centideg and roll_centideg (signed, hundredths of a degree,
// -9000 to 9000, rounded to nearest) plus the two undefined flags, which
// mark a zero over zero case whose angle reads 0.
// An item enters every cycle while sample_stall is low. A result passes, after
// its item is accepted, through the front register, which loads at the accepting
// edge, then the queue, 32 stages of the square root pipeline
// (one root bit each), one stage per CORDIC rotation and the output register.
// When angle_stall holds the output, the angle pipeline freezes; the front
// end keeps accepting until the four-entry queue fills, then raises
// sample_stall. Reset empties the queue and clears all valid bits; no
// clearing pass is needed, so items are taken from the first cycle after reset.
module accel_tilt_angles #(
    parameter int SAMPLE_BITS      = 16,
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  logic signed [SAMPLE_BITS-1:0]     accel_x,
    input  logic signed [SAMPLE_BITS-1:0]     accel_y,
    input  logic signed [SAMPLE_BITS-1:0]     accel_z,
    output logic                              angle_valid,
    input  logic                              angle_stall,
    output logic signed [at_pkg::ANGLE_W-1:0] pitch_centideg,
    output logic signed [at_pkg::ANGLE_W-1:0] roll_centideg,
    output logic                              pitch_undefined,
    output logic                              roll_undefined
);

    `include "accel_tilt_angles_assert.svh"

    localparam int ENTRY_W = 6 * SAMPLE_BITS + 2;

    at_pkg::q_status_t    q_stat;
    logic                 push;
    logic                 pop;
    logic [ENTRY_W-1:0]   push_data;
    logic [ENTRY_W-1:0]   head_data;

    at_front #(
        .SB      (SAMPLE_BITS),
        .ENTRY_W (ENTRY_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .accel_x      (accel_x),
        .accel_y      (accel_y),
        .accel_z      (accel_z),
        .q_stat       (q_stat),
        .push         (push),
        .push_data    (push_data)
    );

    at_queue #(
        .W (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .q_stat    (q_stat)
    );

    at_back #(
        .SB      (SAMPLE_BITS),
        .ITERS   (ANGLE_ITERATIONS),
        .ENTRY_W (ENTRY_W)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_stat          (q_stat),
        .head_data       (head_data),
        .pop             (pop),
        .angle_valid     (angle_valid),
        .angle_stall     (angle_stall),
        .pitch_centideg  (pitch_centideg),
        .roll_centideg   (roll_centideg),
        .pitch_undefined (pitch_undefined),
        .roll_undefined  (roll_undefined)
    );

    `AT_ASSERT_ALWAYS(a_queue_bound, q_stat.count <= at_pkg::QDEPTH, "queue count above depth")
    `AT_ASSERT_IMPLY(a_no_overflow, push && !pop, q_stat.count < at_pkg::QDEPTH, "push into full queue")
    `AT_ASSERT_IMPLY(a_pitch_undef_zero, angle_valid && pitch_undefined, pitch_centideg == '0, "undefined pitch not zero")
    `AT_ASSERT_IMPLY(a_roll_range, angle_valid, (roll_centideg <= 15'sd9000) && (roll_centideg >= -15'sd9000), "roll out of range")

endmodule
